// ===== rtl/core/lz4_block_decompressor_assert.svh =====
// assertion macros used by the lz4 block decompressor top level
`ifndef LZ4_BLOCK_DECOMPRESSOR_ASSERT_SVH
`define LZ4_BLOCK_DECOMPRESSOR_ASSERT_SVH

// same-cycle implication
`define LZ4BD_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define LZ4BD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/lz4bd_pkg.sv =====
// types and codes shared by the lz4 block decompressor
package lz4bd_pkg;

  typedef enum logic [2:0] {
    PH_TOKEN   = 3'd0,
    PH_LITEXT  = 3'd1,
    PH_LITERAL = 3'd2,
    PH_OFFLO   = 3'd3,
    PH_OFFHI   = 3'd4,
    PH_MATEXT  = 3'd5,
    PH_COPY    = 3'd6,
    PH_HALT    = 3'd7
  } phase_t;

  typedef enum logic [1:0] {
    ACT_BYTE    = 2'd0,
    ACT_COPY    = 2'd1,
    ACT_RESTART = 2'd2,
    ACT_IDLE    = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_ZERO_OFS = 3'd1,
    ST_FAR_OFS  = 3'd2,
    ST_REFUSED  = 3'd3,
    ST_HALTED   = 3'd4
  } status_t;

  localparam logic [3:0] NIBBLE_EXT   = 4'hF;
  localparam logic [7:0] BYTE_EXT     = 8'd255;
  localparam logic [3:0] MIN_MATCH    = 4'd4;
  localparam int         QUEUE_DEPTH  = 3;

  // decoded beat leaving the parser, byte still to be resolved from history when from_hist is set
  typedef struct packed {
    logic       byte_valid;
    logic       from_hist;
    logic [7:0] lit_byte;
    logic       last;
    logic       copy_pending;
    status_t    status;
  } item_t;

  // finished result beat
  typedef struct packed {
    logic       byte_valid;
    logic [7:0] out_byte;
    logic       last;
    logic       copy_pending;
    status_t    status;
  } result_t;

  function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [7:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {25'd0, b};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

endpackage

// ===== rtl/core/lz4bd_ram.sv =====
// generic single-write, single-read ram with registered read data
module lz4bd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/core/lz4bd_parser.sv =====
// token and length parser with the block's decode state and history pointers
module lz4bd_parser
  import lz4bd_pkg::*;
#(
  parameter int HISTORY_DEPTH = 65536
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_wr_en,
  input  logic [31:0]                      cfg_wr_data,
  input  logic                             take,
  input  action_t                          action,
  input  logic [7:0]                       data_byte,
  output item_t                            item,
  output logic [$clog2(HISTORY_DEPTH)-1:0] wr_addr,
  output logic                             rd_en,
  output logic [$clog2(HISTORY_DEPTH)-1:0] rd_addr
);

  localparam int              AW      = $clog2(HISTORY_DEPTH);
  localparam logic [16:0]     DEPTH_W = 17'(HISTORY_DEPTH);
  localparam logic [AW-1:0]   PTR_MAX = AW'(HISTORY_DEPTH - 1);

  phase_t        phase, phase_next;
  logic [3:0]    match_nibble, match_nibble_next;
  logic [31:0]   literals_left, literals_left_next;
  logic [31:0]   match_left, match_left_next;
  logic [7:0]    offset_low, offset_low_next;
  logic [15:0]   match_distance, match_distance_next;
  logic [31:0]   out_count, out_count_next;
  logic [AW-1:0] wr_ptr, wr_ptr_next;
  logic [31:0]   output_size, output_size_m1;

  logic          halted;
  logic          emit_last;
  logic [15:0]   new_dist;
  logic          dist_zero;
  logic          dist_far;
  logic          lit_beat;
  logic          copy_beat;
  logic [16:0]   back_diff;
  logic [16:0]   back_wrap;

  assign halted    = (phase == PH_HALT) || (out_count >= output_size);
  assign emit_last = (out_count == output_size_m1);
  assign new_dist  = {data_byte, offset_low};
  assign dist_zero = (new_dist == 16'd0);
  assign dist_far  = ({16'd0, new_dist} > out_count) || ({1'b0, new_dist} > DEPTH_W);
  assign lit_beat  = !halted && (action == ACT_BYTE) && (phase == PH_LITERAL);
  assign copy_beat = !halted && (action == ACT_COPY) && (phase == PH_COPY);

  // source is behind the write pointer by the match distance, modulo the depth
  assign back_diff = 17'(wr_ptr) - 17'(match_distance);
  assign back_wrap = back_diff[16] ? back_diff + DEPTH_W : back_diff;
  assign rd_addr   = back_wrap[AW-1:0];
  assign rd_en     = take && copy_beat;
  assign wr_addr   = wr_ptr;

  // next state
  always_comb begin
    phase_next          = phase;
    match_nibble_next   = match_nibble;
    literals_left_next  = literals_left;
    match_left_next     = match_left;
    offset_low_next     = offset_low;
    match_distance_next = match_distance;
    out_count_next      = out_count;
    wr_ptr_next         = wr_ptr;
    if (take) begin
      unique case (action)
        ACT_RESTART: begin
          phase_next          = PH_TOKEN;
          match_nibble_next   = 4'd0;
          literals_left_next  = 32'd0;
          match_left_next     = 32'd0;
          offset_low_next     = 8'd0;
          match_distance_next = 16'd0;
          out_count_next      = 32'd0;
          wr_ptr_next         = '0;
        end
        ACT_IDLE: begin
        end
        ACT_BYTE: begin
          if (halted) begin
            phase_next = PH_HALT;
          end else begin
            unique case (phase)
              PH_TOKEN: begin
                match_nibble_next  = data_byte[3:0];
                literals_left_next = {28'd0, data_byte[7:4]};
                if (data_byte[7:4] == NIBBLE_EXT) begin
                  phase_next = PH_LITEXT;
                end else if (data_byte[7:4] != 4'd0) begin
                  phase_next = PH_LITERAL;
                end else begin
                  phase_next = PH_OFFLO;
                end
              end
              PH_LITEXT: begin
                // run is at least fifteen here, so never empty
                literals_left_next = sat_add(literals_left, data_byte);
                if (data_byte != BYTE_EXT) begin
                  phase_next = PH_LITERAL;
                end
              end
              PH_LITERAL: begin
                literals_left_next = literals_left - 32'd1;
                out_count_next     = out_count + 32'd1;
                wr_ptr_next        = (wr_ptr == PTR_MAX) ? '0 : wr_ptr + AW'(1);
                if (emit_last) begin
                  phase_next = PH_HALT;
                end else if (literals_left == 32'd1) begin
                  phase_next = PH_OFFLO;
                end
              end
              PH_OFFLO: begin
                offset_low_next = data_byte;
                phase_next      = PH_OFFHI;
              end
              PH_OFFHI: begin
                match_distance_next = new_dist;
                if (dist_zero || dist_far) begin
                  phase_next = PH_HALT;
                end else begin
                  match_left_next = {28'd0, match_nibble} + {28'd0, MIN_MATCH};
                  phase_next = (match_nibble == NIBBLE_EXT) ? PH_MATEXT : PH_COPY;
                end
              end
              PH_MATEXT: begin
                match_left_next = sat_add(match_left, data_byte);
                if (data_byte != BYTE_EXT) begin
                  phase_next = PH_COPY;
                end
              end
              PH_COPY: begin
              end
              PH_HALT: begin
                phase_next = PH_HALT;
              end
            endcase
          end
        end
        ACT_COPY: begin
          if (halted) begin
            phase_next = PH_HALT;
          end else if (phase == PH_COPY) begin
            match_left_next = match_left - 32'd1;
            out_count_next  = out_count + 32'd1;
            wr_ptr_next     = (wr_ptr == PTR_MAX) ? '0 : wr_ptr + AW'(1);
            if (emit_last) begin
              phase_next = PH_HALT;
            end else if (match_left == 32'd1) begin
              phase_next = PH_TOKEN;
            end
          end
        end
      endcase
    end
  end

  // result fields of the beat being taken
  always_comb begin
    item              = '0;
    item.status       = ST_OK;
    // match_left never reaches zero while the copy phase holds
    item.copy_pending = (phase_next == PH_COPY);
    unique case (action)
      ACT_RESTART: begin
        item.copy_pending = 1'b0;
      end
      ACT_IDLE: begin
        item.status = halted ? ST_HALTED : ST_OK;
      end
      ACT_BYTE, ACT_COPY: begin
        if (halted) begin
          item.status = ST_HALTED;
        end else if (lit_beat) begin
          item.byte_valid = 1'b1;
          item.lit_byte   = data_byte;
          item.last       = emit_last;
        end else if (copy_beat) begin
          item.byte_valid = 1'b1;
          item.from_hist  = 1'b1;
          item.last       = emit_last;
        end else if (action == ACT_BYTE && phase == PH_OFFHI) begin
          if (dist_zero) begin
            item.status = ST_ZERO_OFS;
          end else if (dist_far) begin
            item.status = ST_FAR_OFS;
          end
        end else if (action == ACT_BYTE && phase == PH_COPY) begin
          item.status = ST_REFUSED;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_TOKEN;
      match_nibble   <= 4'd0;
      literals_left  <= 32'd0;
      match_left     <= 32'd0;
      offset_low     <= 8'd0;
      match_distance <= 16'd0;
      out_count      <= 32'd0;
      wr_ptr         <= '0;
      output_size    <= 32'd0;
      output_size_m1 <= 32'hFFFF_FFFF;
    end else begin
      phase          <= phase_next;
      match_nibble   <= match_nibble_next;
      literals_left  <= literals_left_next;
      match_left     <= match_left_next;
      offset_low     <= offset_low_next;
      match_distance <= match_distance_next;
      out_count      <= out_count_next;
      wr_ptr         <= wr_ptr_next;
      if (cfg_wr_en) begin
        output_size    <= cfg_wr_data;
        output_size_m1 <= cfg_wr_data - 32'd1;
      end
    end
  end

endmodule

// ===== rtl/core/lz4bd_outq.sv =====
// three-entry result queue in front of the master side
module lz4bd_outq
  import lz4bd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  result_t    push_data,
  output logic       head_valid,
  output result_t    head,
  input  logic       pop_ready,
  output logic [1:0] count
);

  result_t    entries [QUEUE_DEPTH];
  logic [1:0] wr_idx, rd_idx;
  logic       pop;

  assign head_valid = (count != 2'd0);
  assign head       = entries[rd_idx];
  assign pop        = head_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_idx] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_idx <= 2'd0;
      rd_idx <= 2'd0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_idx <= (wr_idx == 2'(QUEUE_DEPTH - 1)) ? 2'd0 : wr_idx + 2'd1;
      end
      if (pop) begin
        rd_idx <= (rd_idx == 2'(QUEUE_DEPTH - 1)) ? 2'd0 : rd_idx + 2'd1;
      end
      count <= count + 2'(push) - 2'(pop);
    end
  end

endmodule

// ===== rtl/core/lz4_block_decompressor.sv =====
// lz4 block decompressor top level: parser, history ram, resolve stage and result queue
// One beat in gives one beat out. A compressed byte or a copy step is taken every cycle
// while the result queue has room; each beat passes through the parser, where the history
// read is issued, and then the registered resolve stage, where the history ram's
// registered read data (or the byte forwarded from the write of the beat just ahead) is
// picked and written back. Results then wait in a three-entry queue. The history has no
// clearing pass; it is only read at entries already written within the current block.
`include "lz4_block_decompressor_assert.svh"

module lz4_block_decompressor
  import lz4bd_pkg::*;
#(
  parameter int HISTORY_DEPTH = 65536
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [31:0] cfg_wr_data,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,  // data_byte
  input  logic [1:0]  s_axis_tuser,  // action
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,  // out_byte, copy_pending, status, zero pad
  output logic [0:0]  m_axis_tuser,  // byte_valid
  output logic        m_axis_tlast   // last
);

  localparam int AW = $clog2(HISTORY_DEPTH);

  logic          take;
  item_t         item;
  logic [AW-1:0] wr_addr;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic [7:0]    ram_rdata;

  logic          s1_valid;
  item_t         s1_item;
  logic [AW-1:0] s1_waddr;
  logic          s1_fwd;
  logic [7:0]    s1_fwd_byte;
  logic [7:0]    hist_byte;
  logic [7:0]    s1_byte;
  logic          s1_we;

  result_t       res;
  result_t       head;
  logic [1:0]    q_count;

  assign s_axis_tready = (3'(q_count) + 3'(s1_valid)) < 3'(QUEUE_DEPTH);
  assign take          = s_axis_tvalid && s_axis_tready;

  lz4bd_parser #(
    .HISTORY_DEPTH (HISTORY_DEPTH)
  ) u_parser (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .take        (take),
    .action      (action_t'(s_axis_tuser)),
    .data_byte   (s_axis_tdata),
    .item        (item),
    .wr_addr     (wr_addr),
    .rd_en       (rd_en),
    .rd_addr     (rd_addr)
  );

  lz4bd_ram #(
    .WIDTH (8),
    .DEPTH (HISTORY_DEPTH)
  ) u_history (
    .clk   (clk),
    .we    (s1_we),
    .waddr (s1_waddr),
    .wdata (s1_byte),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (ram_rdata)
  );

  // resolve stage
  assign hist_byte = s1_fwd ? s1_fwd_byte : ram_rdata;
  assign s1_byte   = s1_item.from_hist ? hist_byte : s1_item.lit_byte;
  assign s1_we     = s1_valid && s1_item.byte_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= take;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      s1_item     <= item;
      s1_waddr    <= wr_addr;
      // the entry being written now is not yet visible to the read issued now
      s1_fwd      <= s1_we && (s1_waddr == rd_addr);
      s1_fwd_byte <= s1_byte;
    end
  end

  always_comb begin
    res.byte_valid   = s1_item.byte_valid;
    res.out_byte     = s1_item.byte_valid ? s1_byte : 8'd0;
    res.last         = s1_item.last;
    res.copy_pending = s1_item.copy_pending;
    res.status       = s1_item.status;
  end

  lz4bd_outq u_outq (
    .clk        (clk),
    .rst        (rst),
    .push       (s1_valid),
    .push_data  (res),
    .head_valid (m_axis_tvalid),
    .head       (head),
    .pop_ready  (m_axis_tready),
    .count      (q_count)
  );

  assign m_axis_tdata = {4'd0, head.status, head.copy_pending, head.out_byte};
  assign m_axis_tuser = head.byte_valid;
  assign m_axis_tlast = head.last;

  `LZ4BD_ASSERT_IMPLY(a_queue_room, clk, rst, s1_valid, q_count < 2'(QUEUE_DEPTH), "result queue overflow")
  `LZ4BD_ASSERT_IMPLY(a_hist_is_byte, clk, rst, s1_valid && s1_item.from_hist, s1_item.byte_valid, "history read without a byte")
  `LZ4BD_ASSERT_IMPLY(a_last_has_byte, clk, rst, s1_valid && s1_item.last, s1_item.byte_valid, "last without a byte")
  `LZ4BD_ASSERT_NEXT(a_read_resolves, clk, rst, rd_en, s1_valid && s1_item.from_hist, "history read not resolved next cycle")

endmodule

// ===== dv/lz4_block_decompressor_check.sv =====
// stream monitor that decodes the accepted lz4 input and compares every result beat
module lz4_block_decompressor_check
  import lz4bd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [31:0] cfg_wr_data,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,
  input  logic [1:0]  s_axis_tuser,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [15:0] m_axis_tdata,
  input  logic [0:0]  m_axis_tuser,
  input  logic        m_axis_tlast,
  output int          fail_count,
  output int          outstanding
);

  localparam int HISTORY_BYTES = 65536;

  phase_t      phase;
  logic [3:0]  match_nib;
  logic [31:0] lits_left;
  logic [31:0] copies_left;
  logic [31:0] bytes_out;
  logic [31:0] out_size;
  logic [7:0]  ofs_lo;
  logic [15:0] distance;
  logic [7:0]  history [HISTORY_BYTES];
  result_t     decoded_q [$];
  int          mismatches = 0;

  function automatic logic [31:0] add_sat(logic [31:0] a, logic [7:0] b);
    if (a > 32'hFFFF_FFFF - {24'd0, b})
      return 32'hFFFF_FFFF;
    return a + {24'd0, b};
  endfunction

  function automatic void clear_parse();
    phase = PH_TOKEN;
    match_nib = '0;
    lits_left = '0;
    copies_left = '0;
    ofs_lo = '0;
    distance = '0;
    bytes_out = '0;
  endfunction

  // returns 1 when this byte reaches the output size
  function automatic logic store_byte(logic [7:0] v);
    history[bytes_out % HISTORY_BYTES] = v;
    bytes_out = bytes_out + 1;
    if (bytes_out >= out_size) begin
      phase = PH_HALT;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic result_t decode_beat(action_t act, logic [7:0] b);
    result_t     r;
    logic [31:0] src;
    logic [7:0]  v;
    r = '0;
    if (act == ACT_RESTART) begin
      clear_parse();
    end else if (act == ACT_IDLE) begin
      if (phase == PH_HALT || bytes_out >= out_size) r.status = ST_HALTED;
    end else if (phase == PH_HALT || bytes_out >= out_size) begin
      phase = PH_HALT;
      r.status = ST_HALTED;
    end else if (act == ACT_BYTE) begin
      case (phase)
        PH_TOKEN: begin
          match_nib = b[3:0];
          lits_left = {28'd0, b[7:4]};
          if (b[7:4] == NIBBLE_EXT) phase = PH_LITEXT;
          else if (b[7:4] != 4'd0) phase = PH_LITERAL;
          else phase = PH_OFFLO;
        end
        PH_LITEXT: begin
          lits_left = add_sat(lits_left, b);
          if (b != BYTE_EXT) begin
            if (lits_left != 0) phase = PH_LITERAL;
            else phase = PH_OFFLO;
          end
        end
        PH_LITERAL: begin
          r.byte_valid = 1'b1;
          r.out_byte = b;
          lits_left = lits_left - 1;
          if (store_byte(b)) r.last = 1'b1;
          else if (lits_left == 0) phase = PH_OFFLO;
        end
        PH_OFFLO: begin
          ofs_lo = b;
          phase = PH_OFFHI;
        end
        PH_OFFHI: begin
          distance = {b, ofs_lo};
          if (distance == 16'd0) begin
            r.status = ST_ZERO_OFS;
            phase = PH_HALT;
          end else if ({16'd0, distance} > bytes_out || int'(distance) > HISTORY_BYTES) begin
            r.status = ST_FAR_OFS;
            phase = PH_HALT;
          end else begin
            copies_left = {28'd0, match_nib} + {28'd0, MIN_MATCH};
            if (match_nib == NIBBLE_EXT) phase = PH_MATEXT;
            else phase = PH_COPY;
          end
        end
        PH_MATEXT: begin
          copies_left = add_sat(copies_left, b);
          if (b != BYTE_EXT) phase = PH_COPY;
        end
        PH_COPY: r.status = ST_REFUSED;
        default: begin
          phase = PH_HALT;
          r.status = ST_HALTED;
        end
      endcase
    end else if (phase == PH_COPY) begin
      src = (bytes_out - {16'd0, distance}) % HISTORY_BYTES;
      v = history[src];
      r.byte_valid = 1'b1;
      r.out_byte = v;
      copies_left = copies_left - 1;
      if (store_byte(v)) r.last = 1'b1;
      else if (copies_left == 0) phase = PH_TOKEN;
    end
    r.copy_pending = (phase == PH_COPY && copies_left != 0);
    return r;
  endfunction

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t %s mismatch: expected %0h, actual %0h", $time, name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin : watch
    result_t want;
    if (rst) begin
      out_size = '0;
      clear_parse();
      decoded_q.delete();
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (decoded_q.size() == 0) begin
          $display("%0t unexpected beat: expected none, actual tdata %h tuser %b tlast %b",
                   $time, m_axis_tdata, m_axis_tuser, m_axis_tlast);
          mismatches++;
        end else begin
          want = decoded_q.pop_front();
          check_field("byte_valid", want.byte_valid, m_axis_tuser[0]);
          check_field("out_byte", want.out_byte, m_axis_tdata[7:0]);
          check_field("copy_pending", want.copy_pending, m_axis_tdata[8]);
          check_field("status", want.status, m_axis_tdata[11:9]);
          check_field("last", want.last, m_axis_tlast);
          check_field("tdata pad", 0, m_axis_tdata[15:12]);
        end
      end
      if (cfg_wr_en) out_size = cfg_wr_data;
      if (s_axis_tvalid && s_axis_tready)
        decoded_q.push_back(decode_beat(action_t'(s_axis_tuser), s_axis_tdata));
    end
    outstanding <= decoded_q.size();
    fail_count <= mismatches;
  end

endmodule

// ===== dv/lz4_block_decompressor_tb.sv =====
// testbench top for the lz4 block decompressor: stimulus, back-pressure and verdict
module lz4_block_decompressor_tb
  import lz4bd_pkg::*;
;

  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 200;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_wr_en = 1'b0;
  logic [31:0] cfg_wr_data = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;
  logic [1:0]  s_axis_tuser = ACT_IDLE;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;
  logic [0:0]  m_axis_tuser;
  logic        m_axis_tlast;

  int          fail_count;
  int          outstanding;
  int          send_gap_pct = 0;
  int          stall_pct = 0;
  int          holds_asked = 0;
  int          holds_done = 0;
  int          beats_sent = 0;
  int unsigned blk_pos = 0;
  logic [31:0] size_now = '0;
  bit          halted = 1'b1;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  lz4_block_decompressor uut (
    .clk          (clk),
    .rst          (rst),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  lz4_block_decompressor_check check_i (
    .clk          (clk),
    .rst          (rst),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast),
    .fail_count   (fail_count),
    .outstanding  (outstanding)
  );

  task automatic push_beat(input action_t act, input logic [7:0] b);
    while (send_gap_pct != 0 && $urandom_range(99, 0) < send_gap_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= act;
    s_axis_tdata <= b;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    beats_sent++;
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_output_size(input logic [31:0] v);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    size_now = v;
  endtask

  task automatic restart_block();
    push_beat(ACT_RESTART, 8'($urandom_range(255, 0)));
    blk_pos = 0;
    halted = (size_now == 0);
  endtask

  task automatic count_byte();
    blk_pos++;
    if (blk_pos >= size_now) halted = 1'b1;
  endtask

  task automatic send_length_ext(input int unsigned rem);
    while (rem >= 255) begin
      push_beat(ACT_BYTE, BYTE_EXT);
      rem -= 255;
    end
    push_beat(ACT_BYTE, rem[7:0]);
  endtask

  task automatic send_literals(input int unsigned n);
    int unsigned i;
    for (i = 0; i < n; i++) begin
      if (halted) return;
      push_beat(ACT_BYTE, 8'($urandom_range(255, 0)));
      count_byte();
    end
  endtask

  task automatic send_sequence();
    int unsigned lits, mlen, ofs, maxd, i;
    logic [3:0]  lnib, mnib;
    if ($urandom_range(11, 0) == 0)
      lits = 15 + ($urandom_range(2, 0) == 0 ? 255 : 0) + $urandom_range(20, 0);
    else
      lits = $urandom_range(18, blk_pos == 0 ? 1 : 0);
    if ($urandom_range(11, 0) == 0)
      mlen = 19 + ($urandom_range(2, 0) == 0 ? 255 : 0) + $urandom_range(20, 0);
    else
      mlen = $urandom_range(22, 4);
    lnib = (lits >= 15) ? NIBBLE_EXT : lits[3:0];
    mnib = (mlen >= 19) ? NIBBLE_EXT : 4'(mlen - 4);
    push_beat(ACT_BYTE, {lnib, mnib});
    if (lnib == NIBBLE_EXT) send_length_ext(lits - 15);
    send_literals(lits);
    if (halted) return;
    maxd = (blk_pos > 65535) ? 65535 : blk_pos;
    if ($urandom_range(2, 0) == 0) ofs = $urandom_range(maxd < 4 ? maxd : 4, 1);
    else ofs = $urandom_range(maxd, 1);
    push_beat(ACT_BYTE, ofs[7:0]);
    push_beat(ACT_BYTE, ofs[15:8]);
    if (mnib == NIBBLE_EXT) send_length_ext(mlen - 19);
    for (i = 0; i < mlen; i++) begin
      if ($urandom_range(15, 0) == 0) push_beat(ACT_BYTE, 8'($urandom_range(255, 0)));
      if ($urandom_range(31, 0) == 0) push_beat(ACT_IDLE, 8'($urandom_range(255, 0)));
      if ($urandom_range(63, 0) == 0) begin
        restart_block();
        return;
      end
      push_beat(ACT_COPY, 8'($urandom_range(255, 0)));
      count_byte();
      if (halted) return;
    end
  endtask

  task automatic send_broken();
    int unsigned n, ofs, kind, i;
    n = $urandom_range(2, 0);
    kind = $urandom_range(3, 0);
    if (kind <= 1) begin
      push_beat(ACT_BYTE, {n[3:0], 4'($urandom_range(15, 0))});
      send_literals(n);
      if (kind == 0) ofs = 0;
      else if ($urandom_range(1, 0) == 0 && blk_pos < 65535) ofs = blk_pos + 1;
      else ofs = 16'hFFFF;
      push_beat(ACT_BYTE, ofs[7:0]);
      push_beat(ACT_BYTE, ofs[15:8]);
      push_beat(action_t'($urandom_range(1, 0)), 8'($urandom_range(255, 0)));
    end else if (kind == 2) begin
      n = $urandom_range(6, 1);
      for (i = 0; i < n; i++) push_beat(ACT_BYTE, 8'($urandom_range(255, 0)));
    end else begin
      n = $urandom_range(6, 1);
      for (i = 0; i < n; i++)
        push_beat(action_t'($urandom_range(3, 0)), 8'($urandom_range(255, 0)));
    end
    restart_block();
  endtask

  initial begin : sink
    forever begin
      @(posedge clk);
      if (holds_done != holds_asked) begin
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        holds_done++;
      end
      m_axis_tready <= ($urandom_range(99, 0) >= stall_pct);
    end
  end

  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("lz4_block_decompressor_tb NOT OK");
    $finish;
  end

  initial begin : stimulus
    int          p, budget, r;
    logic [31:0] new_size;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // output size still at reset value: everything is ignored
    push_beat(ACT_BYTE, 8'hFF);
    push_beat(ACT_COPY, 8'h00);
    push_beat(ACT_IDLE, 8'hA5);
    push_beat(ACT_RESTART, 8'h5A);
    drain();
    set_output_size(32'hFFFF_FFFF);
    restart_block();

    push_beat(ACT_COPY, 8'hFF);
    push_beat(ACT_BYTE, 8'h20);
    push_beat(ACT_BYTE, 8'h00);
    push_beat(ACT_BYTE, 8'hFF);
    // distance 1, overlapping copy
    push_beat(ACT_BYTE, 8'h01);
    push_beat(ACT_BYTE, 8'h00);
    push_beat(ACT_COPY, 8'h00);
    push_beat(ACT_BYTE, 8'h5A);
    push_beat(ACT_IDLE, 8'h00);
    repeat (3) push_beat(ACT_COPY, 8'h00);
    // empty literal run, distance equal to bytes written, extended match
    push_beat(ACT_BYTE, 8'h0F);
    push_beat(ACT_BYTE, 8'h06);
    push_beat(ACT_BYTE, 8'h00);
    push_beat(ACT_BYTE, 8'hFF);
    push_beat(ACT_BYTE, 8'h01);
    repeat (2) push_beat(ACT_COPY, 8'h00);
    restart_block();
    // zero distance
    push_beat(ACT_BYTE, 8'h10);
    push_beat(ACT_BYTE, 8'h80);
    push_beat(ACT_BYTE, 8'h00);
    push_beat(ACT_BYTE, 8'h00);
    push_beat(ACT_BYTE, 8'h33);
    restart_block();
    // distance beyond the bytes written so far
    push_beat(ACT_BYTE, 8'h10);
    push_beat(ACT_BYTE, 8'h7E);
    push_beat(ACT_BYTE, 8'hFF);
    push_beat(ACT_BYTE, 8'hFF);
    restart_block();

    for (p = 0; p < 8; p++) begin
      drain();
      if (p == 4) begin
        // shrink the size under a block in progress
        set_output_size(blk_pos >> 1);
        repeat (4) push_beat(action_t'($urandom_range(1, 0)), 8'($urandom_range(255, 0)));
        drain();
      end
      case (p)
        0, 7:    new_size = 32'hFFFF_FFFF;
        1:       new_size = $urandom_range(160, 40);
        2:       new_size = 32'd0;
        3:       new_size = 32'h8000_0000;
        4:       new_size = 32'd1;
        5:       new_size = $urandom();
        default: new_size = $urandom_range(60, 10);
      endcase
      set_output_size(new_size);
      case (p % 4)
        0: begin send_gap_pct = 0;  stall_pct = 0;  end
        1: begin send_gap_pct = 64; stall_pct = 0;  end
        2: begin send_gap_pct = 0;  stall_pct = 64; end
        default: begin send_gap_pct = 27; stall_pct = 27; end
      endcase
      restart_block();
      if (p == 0) holds_asked++;
      budget = beats_sent + ((p == 2) ? 10 : (p == 4) ? 40 : 75);
      while (beats_sent < budget) begin
        if (halted) begin
          push_beat(action_t'($urandom_range(1, 0)), 8'($urandom_range(255, 0)));
          restart_block();
        end else begin
          r = $urandom_range(99, 0);
          if (r < 78) send_sequence();
          else if (r < 88) send_broken();
          else if (r < 94) push_beat(ACT_COPY, 8'($urandom_range(255, 0)));
          else push_beat(ACT_IDLE, 8'($urandom_range(255, 0)));
        end
      end
    end

    drain();
    repeat (8) @(posedge clk);
    @(negedge clk);
    if (fail_count == 0)
      $display("lz4_block_decompressor_tb OK");
    else
      $display("lz4_block_decompressor_tb NOT OK");
    $finish;
  end

endmodule
